// File: hdl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// Sobel filter package
// Shared types and constants for the Sobel edge magnitude filter.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int LUMA_W = 16;
    localparam int GRAD_W = 19;   // signed gradient, |g| <= 4*65280
    localparam int SQ_W   = 38;   // gx^2 + gy^2
    localparam int ROOT_W = 19;

    localparam logic [7:0] LUMA_R = 8'd77;
    localparam logic [7:0] LUMA_G = 8'd150;
    localparam logic [7:0] LUMA_B = 8'd29;

    localparam logic [0:0] CFG_WIDTH  = 1'b0;
    localparam logic [0:0] CFG_HEIGHT = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture input beat, read line stores
        logic shift;    // write stores, shift window, set tap masks
        logic sq_x;     // square gx
        logic sq_y;     // square gy, then sum
        logic root_go;  // start square root
        logic root_step;
    } sobel_cmd_t;

    typedef struct packed {
        logic has_result;
        logic root_done;
    } sobel_sts_t;

endpackage

// File: hdl/sobel_datapath.sv
// ----------------------------------------------------------------------------
// Sobel datapath
// Luma, line stores, 3x3 window, gradients, iterative square root.
// ----------------------------------------------------------------------------
module sobel_datapath #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sobel_pkg::sobel_cmd_t cmd,
    output sobel_pkg::sobel_sts_t sts,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [11:0]         cfg_data,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic                is_flush,
    output logic [7:0]          edge_value,
    output logic                frame_end
);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int LW = sobel_pkg::LUMA_W;
    localparam int GW = sobel_pkg::GRAD_W;
    localparam int SW = sobel_pkg::SQ_W;
    localparam int QW = sobel_pkg::ROOT_W;

    // configuration, clamped
    logic [11:0] width_cfg_reg, height_cfg_reg;
    logic [CW-1:0] w_eff;
    logic [RW-1:0] h_eff;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= 12'd640;
            height_cfg_reg <= 12'd480;
        end
        else if (cfg_we)
        begin
            if (cfg_index == sobel_pkg::CFG_WIDTH)
                width_cfg_reg <= cfg_data;
            else
                height_cfg_reg <= cfg_data;
        end
    end
    always_comb
    begin
        if (width_cfg_reg == 12'd0)
            w_eff = CW'(1);
        else if ({20'd0, width_cfg_reg} > MAX_WIDTH)
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = CW'(width_cfg_reg);
        if (height_cfg_reg == 12'd0)
            h_eff = RW'(1);
        else if ({20'd0, height_cfg_reg} > MAX_HEIGHT)
            h_eff = RW'(MAX_HEIGHT);
        else
            h_eff = RW'(height_cfg_reg);
    end

    // position; row saturates past the drain range
    logic [CW-1:0] col_reg;
    logic [12:0]   row_reg;
    logic [CW-1:0] col_now;
    assign col_now = (col_reg >= w_eff) ? '0 : col_reg;

    // stage 1: captured beat, store reads
    logic [LW-1:0] luma_reg, top_reg, mid_reg;
    logic [LW-1:0] upper_mem [MAX_WIDTH];
    logic [LW-1:0] middle_mem [MAX_WIDTH];
    logic [AW-1:0] addr_reg;
    logic [CW-1:0] pcol_reg;
    logic [12:0]   prow_reg;
    logic [LW-1:0] luma_calc;
    assign luma_calc = (is_flush || {1'b0, row_reg} >= {1'b0, 13'(h_eff)}) ? '0 :
        LW'(16'(red) * 16'(sobel_pkg::LUMA_R) + 16'(green) * 16'(sobel_pkg::LUMA_G)
            + 16'(blue) * 16'(sobel_pkg::LUMA_B));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            luma_reg <= luma_calc;
            top_reg  <= upper_mem[AW'(col_now)];
            mid_reg  <= middle_mem[AW'(col_now)];
            addr_reg <= AW'(col_now);
        end
        if (cmd.shift)
        begin
            upper_mem[addr_reg]  <= mid_reg;
            middle_mem[addr_reg] <= luma_reg;
        end
    end

    // result position for the current beat
    logic          res_valid;
    logic [CW-1:0] xc;
    logic [12:0]   yc;
    logic          is_last;
    assign res_valid = (prow_reg >= 13'd2) || (prow_reg == 13'd1 && pcol_reg != '0);
    always_comb
    begin
        if (pcol_reg != '0)
        begin
            xc = pcol_reg - CW'(1);
            yc = prow_reg - 13'd1;
        end
        else
        begin
            xc = w_eff - CW'(1);
            yc = prow_reg - 13'd2;
        end
    end
    assign is_last = (yc == 13'(h_eff) - 13'd1) && (xc == w_eff - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            pcol_reg <= '0;
            prow_reg <= '0;
        end
        else if (cfg_we)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cmd.load)
        begin
            pcol_reg <= col_now;
            prow_reg <= row_reg;
        end
        else if (cmd.shift)
        begin
            if (res_valid && is_last)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (pcol_reg + CW'(1) >= w_eff)
            begin
                col_reg <= '0;
                if (row_reg != 13'h1fff)
                    row_reg <= row_reg + 13'd1;
            end
            else
                col_reg <= pcol_reg + CW'(1);
        end
    end

    // window taps and edge masks
    logic [LW-1:0] win_reg [9];
    logic [8:0]    mask_reg;
    logic          last_reg;
    logic [8:0]    mask_next;
    always_comb
    begin
        logic up_ok, dn_ok, lf_ok, rt_ok;
        up_ok = (yc != 13'd0);
        dn_ok = (yc + 13'd1 < 13'(h_eff));
        lf_ok = (xc != '0);
        rt_ok = (xc + CW'(1) < w_eff);
        mask_next[0] = up_ok & lf_ok;
        mask_next[1] = up_ok;
        mask_next[2] = up_ok & rt_ok;
        mask_next[3] = lf_ok;
        mask_next[4] = 1'b1;
        mask_next[5] = rt_ok;
        mask_next[6] = dn_ok & lf_ok;
        mask_next[7] = dn_ok;
        mask_next[8] = dn_ok & rt_ok;
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (cmd.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r*3]   <= win_reg[r*3+1];
                win_reg[r*3+1] <= win_reg[r*3+2];
            end
            win_reg[2] <= top_reg;
            win_reg[5] <= mid_reg;
            win_reg[8] <= luma_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (cmd.shift)
        begin
            mask_reg <= mask_next;
            last_reg <= is_last;
        end
    end

    // gradients from masked taps
    logic signed [GW-1:0] t [9];
    logic signed [GW-1:0] gx, gy;
    logic [GW-1:0] ax, ay;
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            t[i] = mask_reg[i] ? GW'(signed'({3'd0, win_reg[i]})) : '0;
        gx = (t[2] + (t[5] <<< 1) + t[8]) - (t[0] + (t[3] <<< 1) + t[6]);
        gy = (t[6] + (t[7] <<< 1) + t[8]) - (t[0] + (t[1] <<< 1) + t[2]);
        ax = gx[GW-1] ? GW'(-gx) : GW'(gx);
        ay = gy[GW-1] ? GW'(-gy) : GW'(gy);
    end

    // one squarer shared by gx and gy
    logic [SW-1:0] sqx_reg, sum_reg;
    logic [GW-1:0] sq_in;
    logic [SW-1:0] sq_out;
    assign sq_in  = cmd.sq_x ? ax : ay;
    assign sq_out = SW'(sq_in) * SW'(sq_in);
    always_ff @(posedge clk)
    begin
        if (cmd.sq_x)
            sqx_reg <= sq_out;
        if (cmd.sq_y)
            sum_reg <= sqx_reg + sq_out;
    end

    // restoring square root, one result bit a cycle
    localparam int RCW = $clog2(QW + 1);
    logic [SW-1:0]  rem_reg;
    logic [QW-1:0]  root_reg;
    logic [RCW-1:0] rcnt_reg;
    logic [SW+1:0]  trial;
    logic [SW-1:0]  sub;
    assign sub   = SW'({root_reg, 2'b01}) << (2 * (rcnt_reg - RCW'(1)));
    assign trial = {2'b00, rem_reg} - {2'b00, sub};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rcnt_reg <= '0;
        else if (cmd.root_go)
        begin
            rem_reg  <= sum_reg;
            root_reg <= '0;
            rcnt_reg <= RCW'(QW);
        end
        else if (cmd.root_step && rcnt_reg != '0)
        begin
            if (!trial[SW+1])
            begin
                rem_reg  <= trial[SW-1:0];
                root_reg <= {root_reg[QW-2:0], 1'b1};
            end
            else
                root_reg <= {root_reg[QW-2:0], 1'b0};
            rcnt_reg <= rcnt_reg - RCW'(1);
        end
    end

    logic [QW-9:0] mag;
    assign mag        = root_reg[QW-1:8];
    assign edge_value = (mag >= (QW-8)'(255)) ? 8'd0 : 8'd255 - mag[7:0];
    assign frame_end  = last_reg;
    assign sts.has_result = res_valid;
    assign sts.root_done  = (rcnt_reg == '0);
endmodule

// File: hdl/sobel_ctrl.sv
// ----------------------------------------------------------------------------
// Sobel controller
// Sequences one beat at a time through the datapath.
// ----------------------------------------------------------------------------
module sobel_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output sobel_pkg::sobel_cmd_t cmd,
    input  sobel_pkg::sobel_sts_t sts
);
    typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SQX, S_SQY, S_GO, S_ROOT, S_OUT} state_t;
    state_t state_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = '0;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.shift     = (state_reg == S_SHIFT);
        cmd.sq_x      = (state_reg == S_SQX);
        cmd.sq_y      = (state_reg == S_SQY);
        cmd.root_go   = (state_reg == S_GO);   // sum is registered by now
        cmd.root_step = (state_reg == S_ROOT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
        begin
            case (state_reg)
                S_IDLE:  if (in_valid) state_reg <= S_SHIFT;
                S_SHIFT: state_reg <= sts.has_result ? S_SQX : S_IDLE;
                S_SQX:   state_reg <= S_SQY;
                S_SQY:   state_reg <= S_GO;
                S_GO:    state_reg <= S_ROOT;
                S_ROOT:  if (sts.root_done) state_reg <= S_OUT;
                S_OUT:   if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hdl/sobel_edge_magnitude_filter.sv
// A beat with no result is loaded and shifted, then the block is ready again;
// a result beat also squares gx and gy, runs the 19-step square root unit, one
// bit a cycle, and waits for the output. One beat is in flight at a time.
// Reset: rst_n async clears position, window and control; size 640x480.
// Line stores are not cleared.
// ----------------------------------------------------------------------------
// Sobel edge magnitude filter
// RGB raster stream in, 3x3 Sobel edge value out.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_filter #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        is_flush,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  edge_value,
    output logic        frame_end
);
    sobel_pkg::sobel_cmd_t cmd;
    sobel_pkg::sobel_sts_t sts;

    sobel_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    sobel_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .red(red), .green(green), .blue(blue), .is_flush(is_flush),
        .edge_value(edge_value), .frame_end(frame_end)
    );
endmodule

// File: hdl/sobel_checker.sv
// ----------------------------------------------------------------------------
// Sobel port checker
// Port-level properties of the filter.
// ----------------------------------------------------------------------------
module sobel_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] edge_value,
    input logic       frame_end
);
    // one beat in flight: no input taken while a result is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("input and output both open");

    // a result never appears right after an input beat
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("result too early");

    // after a result beat the block is ready again
    a_ret: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> in_ready) else $error("no return to ready");

    // held result stays stable
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(edge_value)
        && $stable(frame_end)) else $error("result changed under stall");
endmodule

bind sobel_edge_magnitude_filter sobel_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .edge_value(edge_value), .frame_end(frame_end)
);

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sobel edge magnitude filter testbench
// Streams RGB frames of several sizes through the filter, predicts each edge
// value and frame-end flag, and checks every output beat in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAXW = 2048;
    localparam int MAXH = 2048;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       is_flush;
    } pixel_t;

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_end;
    } edge_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [11:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        is_flush;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  edge_value;
    logic        frame_end;

    sobel_edge_magnitude_filter uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .red(red), .green(green), .blue(blue), .is_flush(is_flush),
        .out_valid(out_valid), .out_ready(out_ready),
        .edge_value(edge_value), .frame_end(frame_end)
    );

    // predictor state
    logic [15:0] upper_row [MAXW];
    logic [15:0] middle_row [MAXW];
    logic [15:0] taps [9];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [11:0] width_reg;
    logic [11:0] height_reg;

    pixel_t pending_pixels[$];
    edge_t  expected_edges[$];

    int errors;
    int mismatches;
    int beats_in;
    int beats_out;
    int frames_done;
    longint cycles;
    bit calm;          // no idling in the last part
    int hold_cycles;   // long receiver hold-off, counted below
    bit in_fire;       // input beat taken at the last rising edge

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    task automatic predictor_write(input logic [0:0] idx, input logic [11:0] val);
        if (idx == sobel_pkg::CFG_WIDTH) width_reg = val;
        else height_reg = val;
        cur_col = 0;
        cur_row = 0;
    endtask

    // compute expected output for one accepted pixel beat
    task automatic predict_edge(input pixel_t px);
        int unsigned w, h, c, r, yc, xc, lum;
        logic [15:0] top, mid;
        longint t [9];
        longint gx, gy, ax, ay, yy, xx;
        longint unsigned mag;
        edge_t e;
        w = (width_reg == 0) ? 1 : (width_reg > MAXW ? MAXW : width_reg);
        h = (height_reg == 0) ? 1 : (height_reg > MAXH ? MAXH : height_reg);
        c = cur_col;
        r = cur_row;
        lum = 0;
        if (c >= w) c = 0;
        if (!px.is_flush && r < h)
            lum = 77 * px.red + 150 * px.green + 29 * px.blue;
        top = upper_row[c];
        mid = middle_row[c];
        upper_row[c] = mid;
        middle_row[c] = lum[15:0];
        for (int k = 0; k < 3; k++)
        begin
            taps[k*3] = taps[k*3+1];
            taps[k*3+1] = taps[k*3+2];
        end
        taps[2] = top;
        taps[5] = mid;
        taps[8] = lum[15:0];
        if (r >= 2 || (r == 1 && c >= 1))
        begin
            if (c >= 1)
            begin
                yc = r - 1;
                xc = c - 1;
            end
            else
            begin
                yc = r - 2;
                xc = w - 1;
            end
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++)
                begin
                    yy = longint'(yc) + dy - 1;
                    xx = longint'(xc) + dx - 1;
                    t[dy*3+dx] = (yy >= 0 && yy < h && xx >= 0 && xx < w)
                                 ? longint'(taps[dy*3+dx]) : 0;
                end
            gx = (t[2] + 2*t[5] + t[8]) - (t[0] + 2*t[3] + t[6]);
            gy = (t[6] + 2*t[7] + t[8]) - (t[0] + 2*t[1] + t[2]);
            ax = gx < 0 ? -gx : gx;
            ay = gy < 0 ? -gy : gy;
            mag = int_sqrt(ax*ax + ay*ay) >> 8;
            e.edge_value = (mag >= 255) ? 8'd0 : 8'(255 - mag);
            e.frame_end = (yc == h - 1) && (xc == w - 1);
            expected_edges.push_back(e);
            if (e.frame_end)
            begin
                cur_col = 0;
                cur_row = 0;
                return;
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
        end
        cur_col = c;
        cur_row = r & 12'hFFF;
    endtask

    function automatic pixel_t rand_pixel();
        pixel_t p;
        int sel;
        sel = $urandom_range(0, 9);
        p.red = (sel == 0) ? 8'd0 : (sel == 1 ? 8'd255 : 8'($urandom));
        p.green = (sel == 0) ? 8'd0 : (sel == 1 ? 8'd255 : 8'($urandom));
        p.blue = (sel == 0) ? 8'd0 : (sel == 1 ? 8'd255 : 8'($urandom));
        p.is_flush = 1'b0;
        return p;
    endfunction

    // one whole frame plus the drain beats, all flushes unless noisy
    task automatic queue_frame(input int w, input int h, input bit noisy);
        pixel_t p;
        for (int i = 0; i < w * h; i++)
        begin
            p = rand_pixel();
            if (noisy && $urandom_range(0, 15) == 0) p.is_flush = 1'b1;
            pending_pixels.push_back(p);
        end
        for (int i = 0; i < w + 1; i++)
        begin
            p = rand_pixel();
            p.is_flush = ($urandom_range(0, 3) != 0) || !noisy;
            pending_pixels.push_back(p);
        end
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || expected_edges.size() != 0 || in_valid)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_size(input logic [0:0] idx, input logic [11:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        predictor_write(idx, val);
    endtask

    // input acceptance: predict and note the taken beat
    always @(posedge clk)
    begin
        in_fire <= in_valid && in_ready;
        if (in_valid && in_ready)
        begin
            predict_edge({red, green, blue, is_flush});
            beats_in++;
        end
    end

    // input driver: change on falling edge, accept on rising edge
    int in_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_fire)
            ;
        else if (in_gap > 0)
        begin
            in_gap--;
            in_valid <= 1'b0;
        end
        else if (pending_pixels.size() != 0)
        begin
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                in_gap = $urandom_range(0, 3);
                in_valid <= 1'b0;
            end
            else
            begin
                {red, green, blue, is_flush} <= pending_pixels.pop_front();
                in_valid <= 1'b1;
            end
        end
        else
            in_valid <= 1'b0;
    end

    // long receiver hold-off countdown
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles--;
    end

    // receiver stalls
    int out_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_cycles > 0)
            out_ready <= 1'b0;
        else if (out_gap > 0)
        begin
            out_gap--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            out_gap = $urandom_range(0, 3);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // output monitor
    always @(posedge clk)
    begin
        edge_t exp_e;
        if (rst_n && out_valid && out_ready)
        begin
            beats_out++;
            if (expected_edges.size() == 0)
            begin
                errors++;
                if (mismatches++ < 10)
                    $display("unexpected output beat: edge %0d end %0b",
                             edge_value, frame_end);
            end
            else
            begin
                exp_e = expected_edges.pop_front();
                if (exp_e.frame_end) frames_done++;
                if (exp_e.edge_value !== edge_value || exp_e.frame_end !== frame_end)
                begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("mismatch at beat %0d: edge exp %0d got %0d, end exp %0b got %0b",
                                 beats_out, exp_e.edge_value, edge_value,
                                 exp_e.frame_end, frame_end);
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = sobel_pkg::CFG_WIDTH;
        cfg_data = 12'd0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        red = 8'd0;
        green = 8'd0;
        blue = 8'd0;
        is_flush = 1'b0;
        errors = 0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        frames_done = 0;
        cycles = 0;
        calm = 1'b0;
        hold_cycles = 0;
        in_gap = 0;
        out_gap = 0;
        cur_col = 0;
        cur_row = 0;
        width_reg = 12'd640;
        height_reg = 12'd480;
        for (int i = 0; i < 9; i++) taps[i] = '0;
        for (int i = 0; i < MAXW; i++)
        begin
            upper_row[i] = '0;
            middle_row[i] = '0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: 3x3 frame with extreme colors, flush inside the frame
        write_size(sobel_pkg::CFG_WIDTH, 12'd3);
        write_size(sobel_pkg::CFG_HEIGHT, 12'd3);
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 1'b0});
        pending_pixels.push_back({8'd0, 8'd0, 8'd0, 1'b0});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 1'b0});
        pending_pixels.push_back({8'd0, 8'd0, 8'd0, 1'b1});
        pending_pixels.push_back({8'd255, 8'd0, 8'd0, 1'b0});
        pending_pixels.push_back({8'd0, 8'd255, 8'd0, 1'b0});
        pending_pixels.push_back({8'd0, 8'd0, 8'd255, 1'b0});
        pending_pixels.push_back({8'd170, 8'd85, 8'd170, 1'b0});
        pending_pixels.push_back({8'd85, 8'd170, 8'd85, 1'b0});
        // drain with white beats, non-flush and flush mixed
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 1'b0});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 1'b1});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 1'b1});
        pending_pixels.push_back({8'd255, 8'd255, 8'd255, 1'b0});
        wait_drained();

        // two 1x1 frames from zero sizes (clamped to 1)
        write_size(sobel_pkg::CFG_WIDTH, 12'd0);
        write_size(sobel_pkg::CFG_HEIGHT, 12'd0);
        queue_frame(1, 1, 0);
        queue_frame(1, 1, 1);
        wait_drained();

        // oversized width clamps to the maximum; a partial row gives no result
        write_size(sobel_pkg::CFG_WIDTH, 12'hFFF);
        write_size(sobel_pkg::CFG_HEIGHT, 12'd1);
        for (int i = 0; i < 300; i++)
            pending_pixels.push_back(rand_pixel());
        wait_drained();

        // receiver holds off long while the sender keeps offering
        write_size(sobel_pkg::CFG_WIDTH, 12'd4);
        write_size(sobel_pkg::CFG_HEIGHT, 12'd5);
        hold_cycles = 400;
        queue_frame(4, 5, 0);
        wait_drained();

        // random frames of small sizes, mostly well formed
        while (beats_in < 1300)
        begin
            int w, h;
            w = $urandom_range(1, 9);
            h = $urandom_range(1, 7);
            write_size(sobel_pkg::CFG_WIDTH, 12'(w));
            write_size(sobel_pkg::CFG_HEIGHT, 12'(h));
            for (int f = 0; f < $urandom_range(1, 3); f++)
                queue_frame(w, h, $urandom_range(0, 3) == 0);
            // occasionally abandon a partial frame with a config write
            if ($urandom_range(0, 5) == 0)
                for (int i = 0; i < $urandom_range(1, w * h); i++)
                    pending_pixels.push_back(rand_pixel());
            wait_drained();
        end

        // last part without idling
        calm = 1'b1;
        write_size(sobel_pkg::CFG_WIDTH, 12'd6);
        write_size(sobel_pkg::CFG_HEIGHT, 12'd4);
        queue_frame(6, 4, 0);
        queue_frame(6, 4, 1);
        wait_drained();

        $display("%0d pixel beats in, %0d edge beats out, %0d frames from 1x1 to 9x7",
                 beats_in, beats_out, frames_done);
        $display("also covered: clamped sizes, flushes inside frames, a long output stall");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
